// ===== hw/rtl/buffer_cache_lru_manager_assert.svh =====
// Assertion macros used by the checker of the buffer cache manager.
// Depends on nothing; included by the checker module.
`ifndef BUFFER_CACHE_LRU_MANAGER_ASSERT_SVH
`define BUFFER_CACHE_LRU_MANAGER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define BCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/bcl_pkg.sv =====
// Shared types and constants of the buffer cache manager.
// No dependencies; used by the top level, the controller and the datapath.
package bcl_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int MAX_RES   = 16;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_DIRTY   = 2'd2,
        OP_SYNC    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_BUF  = 2'd1,
        ST_BAD_REL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SYNC,
        S_OUT
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // capture request
        logic exec;       // run a single-result operation
        logic sync_start; // clear sync cursor
        logic sync_step;  // examine one order position
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_sync;
        logic sync_done;  // cursor has passed last position or result cap
        logic sync_emit;  // current position yields a writeback
        logic sync_any;   // at least one writeback issued
    } t_stat;

    typedef struct packed {
        logic [3:0]  slot_out;
        logic        hit;
        logic        read_needed;
        logic        writeback_needed;
        logic [31:0] writeback_block;
        logic [7:0]  writeback_device;
        logic [1:0]  status;
        logic        last;
    } t_res;

endpackage

// ===== hw/rtl/buffer_cache_lru_manager.sv =====
// Top level of the buffer cache manager: controller plus datapath.
// Depends on bcl_pkg, bcl_ctrl and bcl_datapath.
//
// Requests enter on the s_axis channel one at a time; s_axis_tready is
// high only while the block is idle. Get, release and mark-dirty run in
// the EXEC state, whose result is registered and presented in the OUT state;
// no new request is taken until that result is accepted. Sync-all walks the
// recency order, one position per cycle while no result waits, and issues one
// result per dirty slot (at most sixteen), the final one flagged by tlast.
// A sync that finds no dirty slot gives one empty result with tlast set.
// Tag compare and LRU search run in parallel, combinationally; the sync walk
// is the long path. Results wait in the output register while
// m_axis_tvalid is high and tready low; the walk halts until taken.
// Synchronous reset empties every slot and sets the order to slot SLOTS-1
// most recent down to slot 0 least recent.
module buffer_cache_lru_manager #(
    parameter int SLOTS = bcl_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], block_number[33:2], device_id[41:34], slot[45:42], zero fill
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // slot_out[3:0], hit[4], read_needed[5], writeback_needed[6],
    // writeback_block[38:7], writeback_device[46:39], status[48:47], zero fill
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    bcl_pkg::t_cmd  cmd;
    bcl_pkg::t_stat stat;
    bcl_pkg::t_res  res;

    bcl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_fire(s_axis_tvalid && s_axis_tready),
        .i_out_ready(m_axis_tready), .i_stat(stat),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_cmd(cmd)
    );

    bcl_datapath #(.SLOTS(SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_opcode(s_axis_tdata[1:0]), .i_block(s_axis_tdata[33:2]),
        .i_device(s_axis_tdata[41:34]), .i_slot(s_axis_tdata[45:42]),
        .o_stat(stat), .o_res(res)
    );

    assign m_axis_tdata = {7'd0, res.status, res.writeback_device, res.writeback_block,
                           res.writeback_needed, res.read_needed, res.hit, res.slot_out};
    assign m_axis_tlast = res.last;
endmodule

// ===== hw/rtl/bcl_datapath.sv =====
// Tag store, recency order and result formation of the buffer cache manager.
// Depends on bcl_pkg.
module bcl_datapath #(
    parameter int SLOTS = bcl_pkg::SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bcl_pkg::t_cmd  i_cmd,
    input  logic [1:0]     i_opcode,
    input  logic [31:0]    i_block,
    input  logic [7:0]     i_device,
    input  logic [3:0]     i_slot,
    output bcl_pkg::t_stat o_stat,
    output bcl_pkg::t_res  o_res
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0]  r_valid, r_dirty;
    logic [31:0]       r_blk [SLOTS];
    logic [7:0]        r_dev [SLOTS];
    logic [7:0]        r_refs [SLOTS];
    logic [SW-1:0]     r_ord [SLOTS];   // position 0 is most recent

    logic [1:0]        r_op;
    logic [31:0]       r_in_blk;
    logic [7:0]        r_in_dev;
    logic [3:0]        r_in_slot;
    logic [CW-1:0]     r_pos;
    logic [4:0]        r_cnt;

    // Parallel compare and searches over recency positions.
    logic              hit_f, free_f;
    logic [SW-1:0]     hit_s, free_s;
    logic [SW-1:0]     rel_pos;
    logic              slot_ok;
    logic [SW-1:0]     sidx;
    logic [SW-1:0]     cur;
    logic              more_after;
    bcl_pkg::t_res     n_res;

    always_comb begin
        hit_f = 1'b0; hit_s = '0;
        free_f = 1'b0; free_s = '0;
        rel_pos = '0;
        more_after = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_valid[r_ord[i]] && r_blk[r_ord[i]] == r_in_blk
                && r_dev[r_ord[i]] == r_in_dev) begin
                hit_f = 1'b1; hit_s = r_ord[i];
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (r_refs[r_ord[i]] == 8'd0) begin
                free_f = 1'b1; free_s = r_ord[i];
            end
            if (r_ord[i] == sidx) rel_pos = SW'(i);
            // A dirty slot further down the order means this writeback is not the final one.
            if (CW'(i) > r_pos && r_valid[r_ord[i]] && r_dirty[r_ord[i]]) more_after = 1'b1;
        end
    end

    assign slot_ok = (32'(r_in_slot) < 32'(SLOTS));
    assign sidx = SW'(r_in_slot);
    assign cur  = r_ord[r_pos[SW-1:0]];

    assign o_stat.is_sync   = (r_op == bcl_pkg::OP_SYNC);
    assign o_stat.sync_done = (r_pos >= CW'(SLOTS)) || (r_cnt >= 5'(bcl_pkg::MAX_RES));
    assign o_stat.sync_emit = r_valid[cur] && r_dirty[cur];
    assign o_stat.sync_any  = (r_cnt != 5'd0);

    always_comb begin
        n_res = o_res;
        if (i_cmd.exec) begin
            n_res = '0;
            n_res.last = 1'b1;
            unique case (bcl_pkg::t_op'(r_op))
                bcl_pkg::OP_GET: begin
                    if (hit_f) begin
                        n_res.slot_out = 4'(hit_s);
                        n_res.hit = 1'b1;
                    end else if (free_f) begin
                        n_res.slot_out = 4'(free_s);
                        n_res.read_needed = 1'b1;
                        if (r_valid[free_s] && r_dirty[free_s]) begin
                            n_res.writeback_needed = 1'b1;
                            n_res.writeback_block  = r_blk[free_s];
                            n_res.writeback_device = r_dev[free_s];
                        end
                    end else begin
                        n_res.status = bcl_pkg::ST_NO_BUF;
                    end
                end
                bcl_pkg::OP_RELEASE: begin
                    n_res.slot_out = r_in_slot;
                    if (!slot_ok || r_refs[sidx] == 8'd0) n_res.status = bcl_pkg::ST_BAD_REL;
                end
                bcl_pkg::OP_DIRTY: begin
                    n_res.slot_out = r_in_slot;
                end
                default: begin
                    // Sync with nothing dirty.
                    n_res.slot_out = 4'd0;
                end
            endcase
        end
        if (i_cmd.sync_step && o_stat.sync_emit) begin
            n_res = '0;
            n_res.slot_out = 4'(cur);
            n_res.writeback_needed = 1'b1;
            n_res.writeback_block = r_blk[cur];
            n_res.writeback_device = r_dev[cur];
            n_res.last = !more_after || (r_cnt == 5'(bcl_pkg::MAX_RES - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_refs[i] <= '0;
                r_blk[i]  <= '0;
                r_dev[i]  <= '0;
                r_ord[i]  <= SW'(SLOTS - 1 - i);
            end
            r_pos <= '0;
            r_cnt <= '0;
            o_res <= '0;
        end else begin
            o_res <= n_res;
            if (i_cmd.load) begin
                r_op <= i_opcode; r_in_blk <= i_block;
                r_in_dev <= i_device; r_in_slot <= i_slot;
            end
            if (i_cmd.exec) begin
                unique case (bcl_pkg::t_op'(r_op))
                    bcl_pkg::OP_GET: begin
                        if (hit_f) begin
                            if (r_refs[hit_s] != 8'hFF) r_refs[hit_s] <= r_refs[hit_s] + 8'd1;
                        end else if (free_f) begin
                            r_valid[free_s] <= 1'b1;
                            r_dirty[free_s] <= 1'b0;
                            r_blk[free_s] <= r_in_blk;
                            r_dev[free_s] <= r_in_dev;
                            r_refs[free_s] <= 8'd1;
                        end
                    end
                    bcl_pkg::OP_RELEASE: begin
                        if (slot_ok && r_refs[sidx] != 8'd0) begin
                            r_refs[sidx] <= r_refs[sidx] - 8'd1;
                            if (r_refs[sidx] == 8'd1) begin
                                for (int i = 1; i < SLOTS; i++)
                                    if (SW'(i) <= rel_pos) r_ord[i] <= r_ord[i-1];
                                r_ord[0] <= sidx;
                            end
                        end
                    end
                    bcl_pkg::OP_DIRTY: begin
                        if (slot_ok && r_valid[sidx]) r_dirty[sidx] <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.sync_start) begin
                r_pos <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.sync_step) begin
                r_pos <= r_pos + CW'(1);
                if (o_stat.sync_emit) begin
                    r_dirty[cur] <= 1'b0;
                    r_cnt <= r_cnt + 5'd1;
                end
            end
        end
    end
endmodule

// ===== hw/rtl/bcl_ctrl.sv =====
// Sequencing state machine of the buffer cache manager.
// Depends on bcl_pkg.
module bcl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_fire,
    input  logic           i_out_ready,
    input  bcl_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output bcl_pkg::t_cmd  o_cmd
);
    bcl_pkg::t_state r_state, n_state;
    logic r_pend, n_pend;       // a writeback is held in the result register

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcl_pkg::S_IDLE;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend <= n_pend;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pend = r_pend;
        unique case (r_state)
            bcl_pkg::S_IDLE: if (i_in_fire) n_state = bcl_pkg::S_EXEC;
            bcl_pkg::S_EXEC: begin
                if (i_stat.is_sync) n_state = bcl_pkg::S_SYNC;
                else n_state = bcl_pkg::S_OUT;
            end
            bcl_pkg::S_SYNC: begin
                if (r_pend && !i_out_ready) begin
                    n_state = bcl_pkg::S_SYNC;
                end else if (i_stat.sync_done) begin
                    n_state = r_pend ? bcl_pkg::S_SYNC : bcl_pkg::S_OUT;
                    if (!r_pend && !i_stat.sync_any) n_state = bcl_pkg::S_OUT;
                    if (!r_pend && i_stat.sync_any) n_state = bcl_pkg::S_IDLE;
                    n_pend = 1'b0;
                end else begin
                    n_pend = i_stat.sync_emit;
                end
            end
            bcl_pkg::S_OUT: if (i_out_ready) n_state = bcl_pkg::S_IDLE;
            default: n_state = bcl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            bcl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = 1'b1;
            end
            bcl_pkg::S_EXEC: begin
                if (i_stat.is_sync) o_cmd.sync_start = 1'b1;
                else o_cmd.exec = 1'b1;
            end
            bcl_pkg::S_SYNC: begin
                o_out_valid = r_pend;
                if (!(r_pend && !i_out_ready)) begin
                    if (!i_stat.sync_done) o_cmd.sync_step = 1'b1;
                    else if (!r_pend && !i_stat.sync_any) o_cmd.exec = 1'b1;
                end
            end
            bcl_pkg::S_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/bcl_checker.sv =====
// Port-level checker for the buffer cache manager, bound to the top level.
// Depends on buffer_cache_lru_manager_assert.svh.
`include "buffer_cache_lru_manager_assert.svh"
module bcl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    `BCL_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid)
    `BCL_ASSERT_NXT(a_busy_after, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
        !s_axis_tready)
    `BCL_ASSERT_IMP(a_status_rng, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[48:47] != 2'd3)
    `BCL_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
endmodule

bind buffer_cache_lru_manager bcl_checker u_bcl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
